// ----- sv/radix_digit_converter_defines.svh -----
// assertion macros for the radix digit converter
// used by the top level only; expects clk and rst_n in scope
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdc assertion failed");

// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdc assertion failed");

`endif

// ----- sv/rdc_pkg.sv -----
// shared types, constants and helper functions of the radix digit converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rdc_pkg;

  localparam int VALUE_W            = 31;
  localparam int RADIX_W            = 6;
  localparam int DIGIT_W            = 6;
  localparam int CHAR_W             = 7;
  localparam int DIV_CNT_W          = $clog2(VALUE_W);
  localparam int MAX_DIGITS_DEFAULT = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_result_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_LIMIT) ch = CHAR_W'(d) + ASCII_ZERO;
    else                 ch = CHAR_W'(d) + LETTER_OFFSET;
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- sv/radix_digit_converter.sv -----
// digits come from the bit-serial divider looping over the quotient bits, then are popped
// from the stack by a read and a load step; no new item is taken until the last digit is
// loaded for output; output stalls hold the pop; a zero input is taken and gives no digits
// synchronous active-low reset clears control state and loads the radix with 10
// the digit stack holds no reset value and is only read after being written
`timescale 1ns / 1ps
`default_nettype none
`include "radix_digit_converter_defines.svh"
module radix_digit_converter #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [rdc_pkg::VALUE_W-1:0]  in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [rdc_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                              out_last_digit,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rdc_pkg::RADIX_W-1:0]  cfg_radix
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVW = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LD   = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [rdc_pkg::RADIX_W-1:0]   radix_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          in_accept;
  logic                          out_free;
  logic                          div_start;
  logic [rdc_pkg::VALUE_W-1:0]   div_dividend;
  rdc_pkg::div_result_t          div_res;
  logic                          wr_en;
  logic                          rd_en;
  logic [rdc_pkg::DIGIT_W-1:0]   rd_data;
  logic [CNT_W-1:0]              count_inc;
  logic [CNT_W-1:0]              count_dec;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign count_inc = count_r + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdc_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_radix;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    div_start     = 1'b0;
    div_dividend  = in_value;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        count_nxt = '0;
        if (in_accept && (in_value != '0)) begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_res.done) begin
          wr_en     = 1'b1;
          count_nxt = count_inc;
          if ((div_res.quotient != '0) && (count_inc != CNT_W'(MAX_DIGITS))) begin
            div_start    = 1'b1;
            div_dividend = div_res.quotient;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        count_nxt = count_dec;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rdc_pkg::to_ascii(rd_data);
          out_last_nxt  = (count_r == '0);
          state_nxt     = (count_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  rdc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rdc_pkg::eff_radix(radix_r)),
    .result   (div_res)
  );

  rdc_digit_stack #(
    .MAX_DIGITS (MAX_DIGITS),
    .AW         (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (div_res.remainder),
    .rd_en   (rd_en),
    .rd_addr (count_dec[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  `RDC_ASSERT_NEXT(a_start_div, in_accept && (in_value != '0), state_r == ST_DIVW)
  `RDC_ASSERT_NOW(a_pop_nonempty, state_r == ST_RD, count_r != '0)
  `RDC_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(MAX_DIGITS))
  `RDC_ASSERT_NOW(a_div_idle_pop, (state_r == ST_RD) || (state_r == ST_LD), !div_res.busy)

endmodule
`default_nettype wire

// ----- sv/rdc_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module rdc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rdc_pkg::VALUE_W-1:0]  dividend,
  input  wire logic [rdc_pkg::RADIX_W-1:0]  divisor,
  output rdc_pkg::div_result_t              result
);

  localparam int VW = rdc_pkg::VALUE_W;
  localparam int DW = rdc_pkg::DIGIT_W;
  localparam int CW = rdc_pkg::DIV_CNT_W;

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [VW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   divisor_r;

  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;
  logic [DW-1:0]   step_rem;
  logic [VW-1:0]   step_quo;
  logic            done;

  always_comb begin
    trial    = {rem_r, quo_r[VW-1]};
    fits     = trial >= {1'b0, divisor_r};
    diff     = trial - {1'b0, divisor_r};
    step_rem = fits ? diff[DW-1:0] : trial[DW-1:0];
    step_quo = {quo_r[VW-2:0], fits};
    done     = busy_r && (cnt_r == CW'(VW - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !done;
      cnt_r  <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= DW'(divisor);
    end else if (busy_r) begin
      quo_r <= step_quo;
      rem_r <= step_rem;
    end
  end

  assign result.busy      = busy_r;
  assign result.done      = done;
  assign result.quotient  = step_quo;
  assign result.remainder = step_rem;

endmodule
`default_nettype wire

// ----- sv/rdc_digit_stack.sv -----
// digit stack memory, one write and one registered read port
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module rdc_digit_stack #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEFAULT,
  parameter int AW         = $clog2(MAX_DIGITS)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [rdc_pkg::DIGIT_W-1:0]  wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [rdc_pkg::DIGIT_W-1:0]  rd_data
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [rdc_pkg::DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
